// ===== rtl/tadsg_pkg.sv =====
// ----------------------------------------------------------------------------
// tadsg_pkg: shared types and constants of the two-axis DDA step generator
// Command codes and the result record used by the top level and by the
// iteration engine, and the step-delay reset value of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package tadsg_pkg;

    localparam int unsigned POS_W   = 32;
    localparam int unsigned MAG_W   = 33;
    localparam int unsigned ACC_W   = 34;
    localparam int unsigned DELAY_W = 16;

    localparam logic [DELAY_W-1:0] STEP_DELAY_RST = 16'd1000;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_REL  = 2'd1,
        CMD_ABS  = 2'd2,
        CMD_SET  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic                    step_x_level;
        logic                    dir_x_level;
        logic                    step_y_level;
        logic                    dir_y_level;
        logic                    stepped_x;
        logic                    stepped_y;
        logic signed [POS_W-1:0] position_x;
        logic signed [POS_W-1:0] position_y;
        logic                    busy_res;
        logic                    rejected;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/two_axis_dda_step_generator.sv =====
// ----------------------------------------------------------------------------
// two_axis_dda_step_generator: straight-line step generator for two axes
// Takes tick and move/set commands, runs one DDA iteration per allowed tick
// and reports pins, positions and status for every command.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+---------------------------
//  in       | input     | i_in_valid / o_in_ready    | i_command, i_x_value, i_y_value
//  out      | output    | o_out_valid / i_out_ready  | o_step_*, o_dir_*, o_stepped_*,
//           |           |                            | o_position_*, o_busy_res, o_rejected
//  cfg      | input     | i_cfg_wr_en (no wait)      | i_cfg_wr_data (step_delay)
//
//  Each transaction passes through the input register and then through the
//  engine into the result register; one transaction per cycle is sustained
//  while the output does not stall.
//  The engine updates its state in the same cycle the result is registered,
//  so a following command sees it without a gap.
//  A stall on the output holds both registers; the input stage refills as
//  soon as the result register drains. Reset is synchronous, active low.
//
`default_nettype none

module two_axis_dda_step_generator (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_wr_en,
    input  wire        [tadsg_pkg::DELAY_W-1:0]  i_cfg_wr_data,
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  wire        [1:0]                     i_command,
    input  wire signed [tadsg_pkg::POS_W-1:0]    i_x_value,
    input  wire signed [tadsg_pkg::POS_W-1:0]    i_y_value,
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output logic                                 o_step_x_level,
    output logic                                 o_dir_x_level,
    output logic                                 o_step_y_level,
    output logic                                 o_dir_y_level,
    output logic                                 o_stepped_x,
    output logic                                 o_stepped_y,
    output logic signed [tadsg_pkg::POS_W-1:0]   o_position_x,
    output logic signed [tadsg_pkg::POS_W-1:0]   o_position_y,
    output logic                                 o_busy_res,
    output logic                                 o_rejected
);

    logic [tadsg_pkg::DELAY_W-1:0]     r_step_delay;
    logic                              r_in_valid;
    tadsg_pkg::t_cmd                   r_in_cmd;
    logic signed [tadsg_pkg::POS_W-1:0] r_in_x, r_in_y;
    logic                              r_out_valid;
    tadsg_pkg::t_result                r_out, n_out;
    logic                              advance;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_delay <= tadsg_pkg::STEP_DELAY_RST;
        end else if (i_cfg_wr_en) begin
            r_step_delay <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_cmd <= tadsg_pkg::t_cmd'(i_command);
            r_in_x   <= i_x_value;
            r_in_y   <= i_y_value;
        end
    end

    tadsg_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_command    (r_in_cmd),
        .i_x_value    (r_in_x),
        .i_y_value    (r_in_y),
        .i_step_delay (r_step_delay),
        .o_result     (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_step_x_level = r_out.step_x_level;
    assign o_dir_x_level  = r_out.dir_x_level;
    assign o_step_y_level = r_out.step_y_level;
    assign o_dir_y_level  = r_out.dir_y_level;
    assign o_stepped_x    = r_out.stepped_x;
    assign o_stepped_y    = r_out.stepped_y;
    assign o_position_x   = r_out.position_x;
    assign o_position_y   = r_out.position_y;
    assign o_busy_res     = r_out.busy_res;
    assign o_rejected     = r_out.rejected;

    // a rejected command changes no state, so the block is still busy
    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rejected |-> o_busy_res)
        else $error("rejected transaction reported while not busy");

    // steps come only from ticks, never from a rejected command
    a_step_not_rejected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_stepped_x || o_stepped_y) |-> !o_rejected)
        else $error("step reported on a rejected transaction");

    // a held input stage keeps its command until the engine takes it
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_cmd)
            && $stable(r_in_x) && $stable(r_in_y))
        else $error("input stage lost or changed a pending transaction");

endmodule

`default_nettype wire

// ===== rtl/tadsg_engine.sv =====
// ----------------------------------------------------------------------------
// tadsg_engine: move state and DDA iteration of the step generator
// Holds positions, pins, directions, accumulators and counters. When the
// top level advances an item, the state takes its next value and the
// combinational result describes the state after that item.
// ----------------------------------------------------------------------------
`default_nettype none

module tadsg_engine (
    input  wire                                       i_clk,
    input  wire                                       i_rst_n,
    input  wire                                       i_advance,
    input  tadsg_pkg::t_cmd                           i_command,
    input  wire signed [tadsg_pkg::POS_W-1:0]         i_x_value,
    input  wire signed [tadsg_pkg::POS_W-1:0]         i_y_value,
    input  wire        [tadsg_pkg::DELAY_W-1:0]       i_step_delay,
    output tadsg_pkg::t_result                        o_result
);

    localparam int unsigned PW = tadsg_pkg::POS_W;
    localparam int unsigned MW = tadsg_pkg::MAG_W;
    localparam int unsigned AW = tadsg_pkg::ACC_W;
    localparam int unsigned DW = tadsg_pkg::DELAY_W;

    logic [PW-1:0] r_pos_x, n_pos_x, r_pos_y, n_pos_y;
    logic          r_pin_x, n_pin_x, r_pin_y, n_pin_y;
    logic          r_dir_x, n_dir_x, r_dir_y, n_dir_y;
    logic [MW-1:0] r_mag_x, n_mag_x, r_mag_y, n_mag_y;
    logic [MW-1:0] r_major, n_major, r_iter, n_iter;
    logic [AW-1:0] r_acc_x, n_acc_x, r_acc_y, n_acc_y;
    logic [DW-1:0] r_wait, n_wait;

    logic          busy;
    logic [AW-1:0] sum_x, sum_y;
    logic          hit_x, hit_y;
    logic [MW-1:0] dx, dy, mx, my, mj;
    logic          step_x, step_y, rej;

    assign busy = (r_iter != '0) || (r_wait != '0);

    // one DDA iteration: accumulators stay below the major count
    assign sum_x = r_acc_x + {1'b0, r_mag_x};
    assign sum_y = r_acc_y + {1'b0, r_mag_y};
    assign hit_x = sum_x >= {1'b0, r_major};
    assign hit_y = sum_y >= {1'b0, r_major};

    // 33-bit deltas, absolute target measured from the current position
    always_comb begin
        if (i_command == tadsg_pkg::CMD_ABS) begin
            dx = {i_x_value[PW-1], i_x_value} - {r_pos_x[PW-1], r_pos_x};
            dy = {i_y_value[PW-1], i_y_value} - {r_pos_y[PW-1], r_pos_y};
        end else begin
            dx = {i_x_value[PW-1], i_x_value};
            dy = {i_y_value[PW-1], i_y_value};
        end
    end

    assign mx = dx[MW-1] ? (~dx + 1'b1) : dx;
    assign my = dy[MW-1] ? (~dy + 1'b1) : dy;
    assign mj = (mx > my) ? mx : my;

    always_comb begin
        n_pos_x = r_pos_x;
        n_pos_y = r_pos_y;
        n_pin_x = r_pin_x;
        n_pin_y = r_pin_y;
        n_dir_x = r_dir_x;
        n_dir_y = r_dir_y;
        n_mag_x = r_mag_x;
        n_mag_y = r_mag_y;
        n_major = r_major;
        n_iter  = r_iter;
        n_acc_x = r_acc_x;
        n_acc_y = r_acc_y;
        n_wait  = r_wait;
        step_x  = 1'b0;
        step_y  = 1'b0;
        rej     = 1'b0;
        unique case (i_command)
            tadsg_pkg::CMD_TICK: begin
                if (r_wait != '0) begin
                    n_wait = r_wait - 1'b1;
                end else if (r_iter != '0) begin
                    step_x  = hit_x;
                    step_y  = hit_y;
                    n_acc_x = hit_x ? (sum_x - {1'b0, r_major}) : sum_x;
                    n_acc_y = hit_y ? (sum_y - {1'b0, r_major}) : sum_y;
                    if (hit_x) begin
                        n_pos_x = r_dir_x ? (r_pos_x + 1'b1) : (r_pos_x - 1'b1);
                        n_pin_x = ~r_pin_x;
                    end
                    if (hit_y) begin
                        n_pos_y = r_dir_y ? (r_pos_y + 1'b1) : (r_pos_y - 1'b1);
                        n_pin_y = ~r_pin_y;
                    end
                    n_iter = r_iter - 1'b1;
                    n_wait = i_step_delay;
                end
            end
            tadsg_pkg::CMD_REL, tadsg_pkg::CMD_ABS: begin
                if (busy) begin
                    rej = 1'b1;
                end else if (mj != '0) begin
                    // zero-length move leaves everything alone
                    n_dir_x = ~dx[MW-1];
                    n_dir_y = ~dy[MW-1];
                    n_mag_x = mx;
                    n_mag_y = my;
                    n_major = mj;
                    n_acc_x = '0;
                    n_acc_y = '0;
                    n_iter  = mj;
                    n_wait  = '0;
                end
            end
            tadsg_pkg::CMD_SET: begin
                if (busy) begin
                    rej = 1'b1;
                end else begin
                    n_pos_x = i_x_value;
                    n_pos_y = i_y_value;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_pin_x <= 1'b0;
            r_pin_y <= 1'b0;
            r_dir_x <= 1'b0;
            r_dir_y <= 1'b0;
            r_mag_x <= '0;
            r_mag_y <= '0;
            r_major <= '0;
            r_iter  <= '0;
            r_acc_x <= '0;
            r_acc_y <= '0;
            r_wait  <= '0;
        end else if (i_advance) begin
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
            r_pin_x <= n_pin_x;
            r_pin_y <= n_pin_y;
            r_dir_x <= n_dir_x;
            r_dir_y <= n_dir_y;
            r_mag_x <= n_mag_x;
            r_mag_y <= n_mag_y;
            r_major <= n_major;
            r_iter  <= n_iter;
            r_acc_x <= n_acc_x;
            r_acc_y <= n_acc_y;
            r_wait  <= n_wait;
        end
    end

    always_comb begin
        o_result.step_x_level = n_pin_x;
        o_result.dir_x_level  = n_dir_x;
        o_result.step_y_level = n_pin_y;
        o_result.dir_y_level  = n_dir_y;
        o_result.stepped_x    = step_x;
        o_result.stepped_y    = step_y;
        o_result.position_x   = n_pos_x;
        o_result.position_y   = n_pos_y;
        o_result.busy_res     = (n_iter != '0) || (n_wait != '0);
        o_result.rejected     = rej;
    end

endmodule

`default_nettype wire
